### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the TCP destination rewrite block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Implication checked on the next clock edge.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

### hdl/tdrc_pkg.sv
// ----------------------------------------------------------------------------
// tdrc_pkg
// Types and constants shared by the TCP destination rewrite modules.
// ----------------------------------------------------------------------------
package tdrc_pkg;

	localparam logic [7:0]  PROTO_TCP      = 8'd6;
	localparam logic [15:0] MASK16         = 16'hFFFF;
	localparam logic [15:0] CKSUM_WORD_IDX = 16'd8;

	// Register indexes of the configuration port.
	typedef enum logic [1:0] {
		REG_BALANCER  = 2'd0,
		REG_BACKEND_0 = 2'd1,
		REG_BACKEND_1 = 2'd2
	} cfg_reg_t;

	// Summary of one finished segment, handed from front to back.
	typedef struct packed {
		logic        fwd;
		logic [31:0] dst;
		logic [31:0] src;
		logic [16:0] run_sum;
		logic [15:0] byte_cnt;
	} pkt_info_t;

endpackage

### hdl/tdrc_front.sv
// ----------------------------------------------------------------------------
// tdrc_front
// Accumulates segment words and classifies the packet on its last word.
// ----------------------------------------------------------------------------
module tdrc_front
	import tdrc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [15:0]       seg_word,
	input  logic              odd_tail,
	input  logic              seg_last,
	input  logic [31:0]       ip_src,
	input  logic [31:0]       orig_dst_addr,
	input  logic [7:0]        ip_protocol,
	input  logic [15:0]       src_port,
	input  logic [31:0]       balancer_addr,
	input  logic [31:0]       backend_addr_0,
	input  logic [31:0]       backend_addr_1,
	output logic              push,
	output pkt_info_t         push_info
);

	logic [16:0] run_sum_q;
	logic [15:0] word_cnt_q;

	logic        odd;
	logic [15:0] word_masked;
	logic [15:0] word_used;
	logic [16:0] sum_nxt;
	logic [15:0] cnt_nxt;
	logic [16:0] bytes_raw;

	always_comb begin
		odd         = odd_tail & seg_last;
		word_masked = odd ? {seg_word[15:8], 8'h00} : seg_word;
		// The checksum field itself is summed as zero.
		word_used   = (word_cnt_q == CKSUM_WORD_IDX) ? 16'h0000 : word_masked;
		sum_nxt     = {1'b0, run_sum_q[15:0]} + {16'h0000, run_sum_q[16]}
			+ {1'b0, word_used};
		cnt_nxt     = (word_cnt_q == MASK16) ? word_cnt_q : word_cnt_q + 16'd1;
		bytes_raw   = {cnt_nxt, 1'b0} - {16'h0000, odd};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_sum_q  <= '0;
			word_cnt_q <= '0;
		end else if (accept) begin
			if (seg_last) begin
				run_sum_q  <= '0;
				word_cnt_q <= '0;
			end else begin
				run_sum_q  <= sum_nxt;
				word_cnt_q <= cnt_nxt;
			end
		end
	end

	always_comb begin
		push               = accept & seg_last;
		push_info.fwd      = (orig_dst_addr == balancer_addr) && (ip_protocol == PROTO_TCP);
		push_info.dst      = src_port[0] ? backend_addr_1 : backend_addr_0;
		push_info.src      = ip_src;
		push_info.run_sum  = sum_nxt;
		push_info.byte_cnt = bytes_raw[16] ? MASK16 : bytes_raw[15:0];
	end

endmodule

### hdl/tdrc_queue.sv
// ----------------------------------------------------------------------------
// tdrc_queue
// Short queue of segment summaries between the front and the back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tdrc_queue
	import tdrc_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  pkt_info_t push_info,
	output logic      full,
	output logic      pop_valid,
	input  logic      pop_ready,
	output pkt_info_t pop_info
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	pkt_info_t          entry_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop       = pop_valid & pop_ready;
	assign pop_info  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_info;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CNT_W'(DEPTH), "queue count overflow")
	`ASSERT_NEXT(a_push_grows, clk, arst_n, push && !pop, count_q == $past(count_q) + 1'b1, "push lost")
	`ASSERT_NEXT(a_pop_shrinks, clk, arst_n, pop && !push, count_q == $past(count_q) - 1'b1, "pop lost")

endmodule

### hdl/tdrc_back.sv
// ----------------------------------------------------------------------------
// tdrc_back
// Adds the pseudo-header to the segment sum, folds and drives the result.
// ----------------------------------------------------------------------------
module tdrc_back
	import tdrc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pop_valid,
	output logic        pop_ready,
	input  pkt_info_t   pop_info,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        forward,
	output logic [31:0] new_dst_addr,
	output logic [15:0] new_checksum
);

	logic        valid_s1;
	logic        fwd_s1;
	logic [31:0] dst_s1;
	logic [18:0] sum_s1;

	logic        out_valid_q;
	logic        fwd_q;
	logic [31:0] dst_q;
	logic [15:0] cksum_q;

	logic        out_free;
	logic        s1_free;
	logic [18:0] sum_full;
	logic [16:0] fold1;
	logic [16:0] fold2;
	logic [16:0] fold3;

	assign out_free  = !out_valid_q || out_ready;
	assign s1_free   = !valid_s1 || out_free;
	assign pop_ready = s1_free;

	always_comb begin
		sum_full = {2'b00, pop_info.run_sum}
			+ {3'b000, pop_info.src[31:16]} + {3'b000, pop_info.src[15:0]}
			+ {3'b000, pop_info.dst[31:16]} + {3'b000, pop_info.dst[15:0]}
			+ {11'h000, PROTO_TCP} + {3'b000, pop_info.byte_cnt};
		fold1 = {1'b0, sum_s1[15:0]} + {14'h0000, sum_s1[18:16]};
		fold2 = {1'b0, fold1[15:0]} + {16'h0000, fold1[16]};
		fold3 = {1'b0, fold2[15:0]} + {16'h0000, fold2[16]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_free) begin
				valid_s1 <= pop_valid;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && pop_valid) begin
			fwd_s1 <= pop_info.fwd;
			dst_s1 <= pop_info.dst;
			sum_s1 <= sum_full;
		end
		if (out_free && valid_s1) begin
			fwd_q   <= fwd_s1;
			// A dropped packet reports zero address and checksum.
			dst_q   <= fwd_s1 ? dst_s1 : 32'h0000_0000;
			cksum_q <= fwd_s1 ? ~fold3[15:0] : 16'h0000;
		end
	end

	assign out_valid    = out_valid_q;
	assign forward      = fwd_q;
	assign new_dst_addr = dst_q;
	assign new_checksum = cksum_q;

endmodule

### hdl/tcp_dest_rewrite_checksum.sv
// ----------------------------------------------------------------------------
// tcp_dest_rewrite_checksum
// Rewrites the TCP destination to a backend and recomputes the TCP checksum.
// ----------------------------------------------------------------------------
// The block takes one segment word per clock cycle, with no gaps needed
// between segments. The front adds each word into a 17-bit end-around-carry
// accumulator in the cycle it arrives; on the last word it classifies the
// packet and queues a summary. The back adds the pseudo-header in one stage
// and folds and complements in the next, after the summary queue. One result
// per cycle can drain while the output is ready. Input stalls only while
// the summary queue is full.
module tcp_dest_rewrite_checksum
	import tdrc_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	// tdata: seg_word[15:0], ip_src[47:16], orig_dst_addr[79:48],
	//        ip_protocol[87:80], src_port[103:88]
	input  logic [103:0] s_axis_tdata,
	input  logic         s_axis_tuser,   // odd_tail
	input  logic         s_axis_tlast,   // seg_last
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// tdata: new_dst_addr[31:0], new_checksum[47:32]
	output logic [47:0]  m_axis_tdata,
	output logic         m_axis_tuser,   // forward
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	logic [31:0] balancer_addr_q;
	logic [31:0] backend_addr_0_q;
	logic [31:0] backend_addr_1_q;

	logic        accept;
	logic        push;
	logic        full;
	logic        pop_valid;
	logic        pop_ready;
	pkt_info_t   push_info;
	pkt_info_t   pop_info;
	logic [31:0] new_dst_addr;
	logic [15:0] new_checksum;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !full;
	assign accept        = s_axis_tvalid & s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			balancer_addr_q  <= '0;
			backend_addr_0_q <= '0;
			backend_addr_1_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_BALANCER:  balancer_addr_q  <= cfg_data;
				REG_BACKEND_0: backend_addr_0_q <= cfg_data;
				REG_BACKEND_1: backend_addr_1_q <= cfg_data;
				default: ;
			endcase
		end
	end

	tdrc_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.seg_word       (s_axis_tdata[15:0]),
		.odd_tail       (s_axis_tuser),
		.seg_last       (s_axis_tlast),
		.ip_src         (s_axis_tdata[47:16]),
		.orig_dst_addr  (s_axis_tdata[79:48]),
		.ip_protocol    (s_axis_tdata[87:80]),
		.src_port       (s_axis_tdata[103:88]),
		.balancer_addr  (balancer_addr_q),
		.backend_addr_0 (backend_addr_0_q),
		.backend_addr_1 (backend_addr_1_q),
		.push           (push),
		.push_info      (push_info)
	);

	tdrc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_info (push_info),
		.full      (full),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_info  (pop_info)
	);

	tdrc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_info     (pop_info),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.forward      (m_axis_tuser),
		.new_dst_addr (new_dst_addr),
		.new_checksum (new_checksum)
	);

	assign m_axis_tdata = {new_checksum, new_dst_addr};

endmodule

### verif/tcp_dest_rewrite_checksum_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_dest_rewrite_checksum_tb
// Self-checking bench for the TCP destination rewrite and checksum block.
// Segments are streamed in as 16-bit words with random gaps and output stalls.
// A predictor tracks the running checksum and the balancer and backend
// registers, and each result is compared field by field with the oldest
// prediction. Covered: reset defaults, every register, dropped packets, odd
// tails, the zeroed checksum word, a long gapless segment and a long
// output hold.
// ----------------------------------------------------------------------------
module tcp_dest_rewrite_checksum_tb;
	import tdrc_pkg::*;

	localparam logic [1:0] REG_UNMAPPED = 2'd3;
	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 8;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int LONG_SEG_WORDS = 140;
	localparam int WORDS_PER_PHASE = 190;

	typedef struct {
		logic [15:0] word;
		logic        odd_tail;
		logic        last;
		logic [31:0] src;
		logic [31:0] odst;
		logic [7:0]  proto;
		logic [15:0] port;
	} seg_word_t;

	typedef struct {
		logic        fwd;
		logic [31:0] dst;
		logic [15:0] cksum;
	} rewrite_t;

	logic         clk;
	logic         arst_n;
	logic [103:0] s_axis_tdata;
	logic         s_axis_tuser;
	logic         s_axis_tlast;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [47:0]  m_axis_tdata;
	logic         m_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [1:0]   cfg_index;
	logic [31:0]  cfg_data;

	// Predictor state: configuration and the running segment sum.
	logic [31:0] cfg_balancer;
	logic [31:0] cfg_backend0;
	logic [31:0] cfg_backend1;
	logic [16:0] sum_acc;
	logic [15:0] words_seen;

	rewrite_t pending_rewrites[$];

	int mismatches;
	int words_sent;
	int segments_done;
	int forwarded;
	int results_checked;
	int unsigned cycle_count;
	logic no_gaps;
	logic long_hold_req;

	tcp_dest_rewrite_checksum dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(1, 3);
		if (r < 95) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Adds one accepted word to the running sum and, on the last word of a
	// segment, queues the rewrite the block should report.
	function automatic void predict_rewrite(seg_word_t it);
		logic [15:0] w;
		logic        odd;
		logic [31:0] s;
		logic [31:0] nbytes;
		rewrite_t    r;
		odd = it.odd_tail & it.last;
		w = it.word;
		if (odd) w[7:0] = 8'h00;
		// The checksum field itself counts as zero.
		if (words_seen == CKSUM_WORD_IDX) w = 16'h0000;
		s = {16'h0, sum_acc[15:0]} + {31'h0, sum_acc[16]} + {16'h0, w};
		sum_acc = s[16:0];
		if (words_seen != MASK16) words_seen = words_seen + 16'd1;
		if (!it.last) return;
		r.fwd = (it.odst == cfg_balancer) && (it.proto == PROTO_TCP);
		r.dst = 32'h0;
		r.cksum = 16'h0;
		if (r.fwd) begin
			r.dst = it.port[0] ? cfg_backend1 : cfg_backend0;
			nbytes = {15'h0, words_seen, 1'b0} - {31'h0, odd};
			if (nbytes > 32'hFFFF) nbytes = 32'hFFFF;
			s = {15'h0, sum_acc} + {16'h0, it.src[31:16]} + {16'h0, it.src[15:0]}
				+ {16'h0, r.dst[31:16]} + {16'h0, r.dst[15:0]}
				+ {24'h0, PROTO_TCP} + nbytes;
			repeat (3) s = {16'h0, s[15:0]} + {16'h0, s[31:16]};
			r.cksum = ~s[15:0];
			forwarded++;
		end
		pending_rewrites.push_back(r);
		segments_done++;
		sum_acc = '0;
		words_seen = '0;
	endfunction

	// Called at a falling edge; returns at a falling edge with tvalid still
	// high unless a gap was inserted.
	task automatic send_word(input seg_word_t it);
		int gap;
		s_axis_tdata <= {it.port, it.proto, it.odst, it.src, it.word};
		s_axis_tuser <= it.odd_tail;
		s_axis_tlast <= it.last;
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predict_rewrite(it);
		words_sent++;
		@(negedge clk);
		gap = 0;
		if (!no_gaps && $urandom_range(0, 3) == 0) gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic send_single(input logic [15:0] word, input logic odd,
			input logic [31:0] odst, input logic [7:0] proto, input logic [15:0] port);
		seg_word_t it;
		it.word = word;
		it.odd_tail = odd;
		it.last = 1'b1;
		it.src = $urandom;
		it.odst = odst;
		it.proto = proto;
		it.port = port;
		send_word(it);
	endtask

	// Random segment; a well-formed one targets the balancer over TCP, a
	// broken one misses on the address, the protocol or both.
	task automatic send_segment(input int len, input logic odd_end, input logic good);
		seg_word_t it;
		int i;
		int kind;
		for (i = 0; i < len; i++) begin
			it.word = 16'($urandom);
			it.src = $urandom;
			it.odst = $urandom;
			it.proto = 8'($urandom);
			it.port = 16'($urandom);
			it.odd_tail = 1'($urandom);
			it.last = 1'b0;
			if (i == len - 1) begin
				it.last = 1'b1;
				it.odd_tail = odd_end;
				kind = good ? 3 : $urandom_range(0, 2);
				case (kind)
					0: begin
						it.odst = cfg_balancer ^ (32'h1 << $urandom_range(0, 31));
						it.proto = PROTO_TCP;
					end
					1: begin
						it.odst = cfg_balancer;
						it.proto = PROTO_TCP ^ 8'($urandom_range(1, 255));
					end
					2: ;
					default: begin
						it.odst = cfg_balancer;
						it.proto = PROTO_TCP;
					end
				endcase
			end
			send_word(it);
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_BALANCER:  cfg_balancer = val;
			REG_BACKEND_0: cfg_backend0 = val;
			REG_BACKEND_1: cfg_backend1 = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_rewrites.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Registers still hold their reset value of zero.
	task automatic test_reset_defaults();
		send_single(16'hFFFF, 1'b0, 32'h0, PROTO_TCP, 16'h0000);
		wait_drained();
	endtask

	task automatic test_registers();
		write_reg(REG_BALANCER, 32'hFFFFFFFF);
		write_reg(REG_BACKEND_0, 32'h00000000);
		write_reg(REG_BACKEND_1, 32'hFFFFFFFF);
		// A write to the unmapped index must leave everything unchanged.
		write_reg(REG_UNMAPPED, $urandom);
		send_single(16'h0000, 1'b0, 32'hFFFFFFFF, PROTO_TCP, 16'hFFFF);
		send_single(16'hFFFF, 1'b1, 32'hFFFFFFFF, PROTO_TCP, 16'hFFFE);
		wait_drained();
	endtask

	task automatic test_directed_segments();
		seg_word_t it;
		int i;
		// All-ones words across the checksum field, odd flags on every word.
		for (i = 0; i < 10; i++) begin
			it.word = 16'hFFFF;
			it.odd_tail = 1'b1;
			it.last = (i == 9);
			it.src = 32'hFFFFFFFF;
			it.odst = 32'hFFFFFFFF;
			it.proto = PROTO_TCP;
			it.port = 16'hFFFF;
			send_word(it);
		end
		send_single(16'h8001, 1'b0, 32'hFFFFFFFE, PROTO_TCP, 16'h0001);
		send_single(16'h1234, 1'b1, 32'hFFFFFFFF, 8'hFF, 16'h0000);
		send_single(16'hFFFF, 1'b0, 32'h00000000, 8'h00, 16'hFFFF);
		wait_drained();
	endtask

	// One long segment streamed without gaps, wrapping the accumulator often.
	task automatic test_long_segment();
		no_gaps = 1'b1;
		send_segment(LONG_SEG_WORDS, 1'b1, 1'b1);
		no_gaps = 1'b0;
		wait_drained();
	endtask

	// The output side holds off while short segments keep arriving, so the
	// summary queue fills and the input must stall.
	task automatic test_output_hold();
		int i;
		long_hold_req = 1'b1;
		no_gaps = 1'b1;
		for (i = 0; i < 16; i++) send_segment(1, 1'($urandom), 1'b1);
		no_gaps = 1'b0;
		wait_drained();
	endtask

	task automatic test_random_traffic();
		logic [31:0] phase_cfg[4][3];
		int p;
		int start;
		int len;
		int r;
		phase_cfg[0] = '{$urandom, $urandom, $urandom};
		phase_cfg[1] = '{32'h0, 32'hFFFFFFFF, 32'h0};
		phase_cfg[2] = '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF};
		phase_cfg[3] = '{$urandom, $urandom, $urandom};
		for (p = 0; p < 4; p++) begin
			write_reg(REG_BALANCER, phase_cfg[p][0]);
			write_reg(REG_BACKEND_0, phase_cfg[p][1]);
			write_reg(REG_BACKEND_1, phase_cfg[p][2]);
			if (p == 3) write_reg(REG_UNMAPPED, $urandom);
			start = words_sent;
			while (words_sent - start < WORDS_PER_PHASE) begin
				r = $urandom_range(0, 99);
				if (r < 50) len = $urandom_range(1, 12);
				else if (r < 80) len = $urandom_range(13, 40);
				else if (r < 90) len = $urandom_range(8, 10);
				else len = $urandom_range(41, 120);
				no_gaps = ($urandom_range(0, 7) == 0);
				send_segment(len, 1'($urandom), $urandom_range(0, 99) < 85);
			end
			no_gaps = 1'b0;
			wait_drained();
		end
	endtask

	// Output side: random stalls, plus one long hold when requested.
	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(negedge clk);
			end else if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				m_axis_tready <= 1'b1;
				if (!no_gaps && $urandom_range(0, 9) == 0) stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		rewrite_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_checked++;
			if (pending_rewrites.size() == 0) begin
				$display("%0t: unexpected result fwd=%0b dst=%h cksum=%h", $time,
					m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[47:32]);
				mismatches++;
			end else begin
				e = pending_rewrites.pop_front();
				if (m_axis_tuser !== e.fwd) begin
					$display("%0t: forward expected %0b actual %0b", $time, e.fwd, m_axis_tuser);
					mismatches++;
				end
				if (m_axis_tdata[31:0] !== e.dst) begin
					$display("%0t: new_dst_addr expected %h actual %h", $time, e.dst,
						m_axis_tdata[31:0]);
					mismatches++;
				end
				if (m_axis_tdata[47:32] !== e.cksum) begin
					$display("%0t: new_checksum expected %h actual %h", $time, e.cksum,
						m_axis_tdata[47:32]);
					mismatches++;
				end
			end
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tcp_dest_rewrite_checksum test failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		s_axis_tlast = 1'b0;
		s_axis_tvalid = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		no_gaps = 1'b0;
		long_hold_req = 1'b0;
		cfg_balancer = '0;
		cfg_backend0 = '0;
		cfg_backend1 = '0;
		sum_acc = '0;
		words_seen = '0;
		mismatches = 0;
		words_sent = 0;
		segments_done = 0;
		forwarded = 0;
		results_checked = 0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_defaults();
		test_registers();
		test_directed_segments();
		test_long_segment();
		test_output_hold();
		test_random_traffic();

		$display("Streamed %0d words in %0d segments, %0d forwarded and %0d dropped.",
			words_sent, segments_done, forwarded, segments_done - forwarded);
		$display("Checked %0d results across four register settings and a long output hold.",
			results_checked);
		if (mismatches == 0) begin
			$display("tcp_dest_rewrite_checksum test passed");
		end else begin
			$display("tcp_dest_rewrite_checksum test failed");
		end
		$finish;
	end

endmodule
